[src/dtlq_pkg.sv]
// Shared constants, types and helpers of the drop-tail link queue model.
package dtlq_pkg;

   localparam int DEPTH      = 128;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int SLOT_W     = ADDR_W + 1;
   localparam int FILL_W     = $clog2(DEPTH + 1);
   localparam int LIM_W      = 8;
   localparam int CMP_W      = (FILL_W > LIM_W) ? FILL_W : LIM_W;
   localparam int TIME_W     = 48;
   localparam int SIZE_W     = 16;
   localparam int BP_W       = 20;
   localparam int MULT_W     = SIZE_W + BP_W;
   localparam int PROD_W     = MULT_W + 3;
   localparam int CNT_W      = 32;
   localparam int SUM_W      = 64;
   localparam int OCC_W      = 8;
   localparam int ENTRY_W    = TIME_W + SIZE_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = BP_W;
   localparam int RSP_DATA_W = 3 * CNT_W + OCC_W + SUM_W + CNT_W + TIME_W;

   localparam logic [BP_W-1:0]  BIT_PERIOD_RESET  = BP_W'(200);
   localparam logic [LIM_W-1:0] QUEUE_LIMIT_RESET = LIM_W'(100);

   localparam logic [CSR_IDX_W-1:0] CSR_BIT_PERIOD  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_LIMIT = CSR_IDX_W'(1);

   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_FLUSH   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_POP,
      ST_HEAD_LOAD,
      ST_HEAD_SUM,
      ST_INSERT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              opcode;
      logic [TIME_W-1:0] arrival_time;
      logic [SIZE_W-1:0] size_bytes;
   } item_type;

   typedef struct packed {
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [ENTRY_W-1:0] wr_data;
      logic               rd_en;
      logic [ADDR_W-1:0]  rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic              accepted;
      logic [CNT_W-1:0]  received_count;
      logic [CNT_W-1:0]  delivered_count;
      logic [CNT_W-1:0]  dropped_count;
      logic [OCC_W-1:0]  occupancy;
      logic [SUM_W-1:0]  delay_total;
      logic [CNT_W-1:0]  delay_count;
      logic [TIME_W-1:0] last_departure;
   } result_type;

   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
      return (c == '1) ? c : c + CNT_W'(1);
   endfunction

endpackage

[src/dtlq_ram.sv]
// Single-port-write, single-port-read synchronous RAM with registered read data.
module dtlq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/dtlq_ctrl.sv]
// Queue sequencer: pops, head service start, insert or drop, running statistics.
module dtlq_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           item_valid,
   output logic                           item_ready,
   input  dtlq_pkg::item_type             item,
   input  logic [dtlq_pkg::BP_W-1:0]      bit_period,
   input  logic [dtlq_pkg::LIM_W-1:0]     queue_limit,
   output dtlq_pkg::mem_req_type          mem_req,
   input  logic [dtlq_pkg::ENTRY_W-1:0]   mem_rdata,
   output logic                           res_valid,
   input  logic                           res_ready,
   output dtlq_pkg::result_type           res
);

   dtlq_pkg::state_type                 state_ff, state_in;
   logic                                op_ff, op_in;
   logic [dtlq_pkg::TIME_W-1:0]         arr_ff, arr_in;
   logic [dtlq_pkg::SIZE_W-1:0]         bytes_ff, bytes_in;
   logic                                acc_ff, acc_in;
   logic [dtlq_pkg::ADDR_W-1:0]         head_ptr_ff, head_ptr_in;
   logic [dtlq_pkg::FILL_W-1:0]         fill_ff, fill_in;
   logic [dtlq_pkg::TIME_W-1:0]         head_dep_ff, head_dep_in;
   logic [dtlq_pkg::TIME_W-1:0]         recent_ff, recent_in;
   logic [dtlq_pkg::CNT_W-1:0]          rcv_ff, rcv_in;
   logic [dtlq_pkg::CNT_W-1:0]          dlv_ff, dlv_in;
   logic [dtlq_pkg::CNT_W-1:0]          drp_ff, drp_in;
   logic [dtlq_pkg::SUM_W-1:0]          wsum_ff, wsum_in;
   logic [dtlq_pkg::CNT_W-1:0]          wcnt_ff, wcnt_in;
   logic [dtlq_pkg::TIME_W-1:0]         start_ff, start_in;
   logic [dtlq_pkg::TIME_W-1:0]         delay_ff, delay_in;
   logic [dtlq_pkg::PROD_W-1:0]         prod_ff, prod_in;
   logic                                from_mem_ff, from_mem_in;

   logic [dtlq_pkg::ADDR_W-1:0]         head_next;
   logic [dtlq_pkg::SLOT_W-1:0]         slot_sum;
   logic [dtlq_pkg::ADDR_W-1:0]         slot;
   logic                                room;
   logic [dtlq_pkg::TIME_W-1:0]         h_arr;
   logic [dtlq_pkg::SIZE_W-1:0]         h_bytes;
   logic [dtlq_pkg::TIME_W:0]           diff;
   logic [dtlq_pkg::MULT_W-1:0]         mult;
   logic [dtlq_pkg::SUM_W:0]            wsum_add;
   logic [dtlq_pkg::TIME_W:0]           dep_add;

   assign head_next = (head_ptr_ff == dtlq_pkg::ADDR_W'(dtlq_pkg::DEPTH - 1))
                      ? '0 : head_ptr_ff + dtlq_pkg::ADDR_W'(1);
   assign slot_sum  = dtlq_pkg::SLOT_W'(head_ptr_ff) + dtlq_pkg::SLOT_W'(fill_ff);
   assign slot      = (slot_sum >= dtlq_pkg::SLOT_W'(dtlq_pkg::DEPTH))
                      ? dtlq_pkg::ADDR_W'(slot_sum - dtlq_pkg::SLOT_W'(dtlq_pkg::DEPTH))
                      : dtlq_pkg::ADDR_W'(slot_sum);
   assign room      = (dtlq_pkg::CMP_W'(fill_ff) < dtlq_pkg::CMP_W'(queue_limit)) &&
                      (dtlq_pkg::CMP_W'(fill_ff) < dtlq_pkg::CMP_W'(dtlq_pkg::DEPTH));

   assign h_arr     = from_mem_ff ? mem_rdata[dtlq_pkg::TIME_W-1:0] : arr_ff;
   assign h_bytes   = from_mem_ff ? mem_rdata[dtlq_pkg::ENTRY_W-1:dtlq_pkg::TIME_W] : bytes_ff;
   assign diff      = {1'b0, start_ff} - {1'b0, h_arr};
   assign mult      = dtlq_pkg::MULT_W'(h_bytes) * dtlq_pkg::MULT_W'(bit_period);
   assign wsum_add  = {1'b0, wsum_ff} + (dtlq_pkg::SUM_W + 1)'(delay_ff);
   assign dep_add   = {1'b0, start_ff} + (dtlq_pkg::TIME_W + 1)'(prod_ff);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      arr_in      = arr_ff;
      bytes_in    = bytes_ff;
      acc_in      = acc_ff;
      head_ptr_in = head_ptr_ff;
      fill_in     = fill_ff;
      head_dep_in = head_dep_ff;
      recent_in   = recent_ff;
      rcv_in      = rcv_ff;
      dlv_in      = dlv_ff;
      drp_in      = drp_ff;
      wsum_in     = wsum_ff;
      wcnt_in     = wcnt_ff;
      start_in    = start_ff;
      delay_in    = delay_ff;
      prod_in     = prod_ff;
      from_mem_in = from_mem_ff;
      item_ready  = 1'b0;
      res_valid   = 1'b0;
      mem_req     = '{wr_en: 1'b0, wr_addr: slot, wr_data: {bytes_ff, arr_ff},
                      rd_en: 1'b0, rd_addr: head_next};
      unique case (state_ff)
         dtlq_pkg::ST_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               op_in    = item.opcode;
               arr_in   = item.arrival_time;
               bytes_in = item.size_bytes;
               acc_in   = 1'b0;
               if (item.opcode == dtlq_pkg::OP_ARRIVAL) begin
                  rcv_in = dtlq_pkg::bump(rcv_ff);
               end
               state_in = dtlq_pkg::ST_CHECK;
            end
         end
         dtlq_pkg::ST_CHECK: begin
            if (fill_ff != '0 && (op_ff == dtlq_pkg::OP_FLUSH || head_dep_ff < arr_ff)) begin
               state_in = dtlq_pkg::ST_POP;
            end else if (op_ff == dtlq_pkg::OP_FLUSH) begin
               state_in = dtlq_pkg::ST_DONE;
            end else begin
               state_in = dtlq_pkg::ST_INSERT;
            end
         end
         dtlq_pkg::ST_POP: begin
            recent_in   = head_dep_ff;
            head_ptr_in = head_next;
            fill_in     = fill_ff - dtlq_pkg::FILL_W'(1);
            dlv_in      = dtlq_pkg::bump(dlv_ff);
            if (fill_ff != dtlq_pkg::FILL_W'(1)) begin
               mem_req.rd_en = 1'b1;
               start_in      = head_dep_ff;
               from_mem_in   = 1'b1;
               state_in      = dtlq_pkg::ST_HEAD_LOAD;
            end else begin
               state_in = dtlq_pkg::ST_CHECK;
            end
         end
         dtlq_pkg::ST_HEAD_LOAD: begin
            delay_in = diff[dtlq_pkg::TIME_W] ? '0 : diff[dtlq_pkg::TIME_W-1:0];
            prod_in  = {mult, 3'b000};
            state_in = dtlq_pkg::ST_HEAD_SUM;
         end
         dtlq_pkg::ST_HEAD_SUM: begin
            wsum_in     = wsum_add[dtlq_pkg::SUM_W] ? '1 : wsum_add[dtlq_pkg::SUM_W-1:0];
            wcnt_in     = dtlq_pkg::bump(wcnt_ff);
            head_dep_in = dep_add[dtlq_pkg::TIME_W] ? '1 : dep_add[dtlq_pkg::TIME_W-1:0];
            state_in    = from_mem_ff ? dtlq_pkg::ST_CHECK : dtlq_pkg::ST_DONE;
         end
         dtlq_pkg::ST_INSERT: begin
            if (room) begin
               mem_req.wr_en = 1'b1;
               fill_in       = fill_ff + dtlq_pkg::FILL_W'(1);
               acc_in        = 1'b1;
               if (fill_ff == '0) begin
                  start_in    = arr_ff;
                  from_mem_in = 1'b0;
                  state_in    = dtlq_pkg::ST_HEAD_LOAD;
               end else begin
                  state_in = dtlq_pkg::ST_DONE;
               end
            end else begin
               drp_in   = dtlq_pkg::bump(drp_ff);
               state_in = dtlq_pkg::ST_DONE;
            end
         end
         dtlq_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = dtlq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dtlq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= dtlq_pkg::ST_IDLE;
         head_ptr_ff <= '0;
         fill_ff     <= '0;
         head_dep_ff <= '0;
         recent_ff   <= '0;
         rcv_ff      <= '0;
         dlv_ff      <= '0;
         drp_ff      <= '0;
         wsum_ff     <= '0;
         wcnt_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         head_ptr_ff <= head_ptr_in;
         fill_ff     <= fill_in;
         head_dep_ff <= head_dep_in;
         recent_ff   <= recent_in;
         rcv_ff      <= rcv_in;
         dlv_ff      <= dlv_in;
         drp_ff      <= drp_in;
         wsum_ff     <= wsum_in;
         wcnt_ff     <= wcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      arr_ff      <= arr_in;
      bytes_ff    <= bytes_in;
      acc_ff      <= acc_in;
      start_ff    <= start_in;
      delay_ff    <= delay_in;
      prod_ff     <= prod_in;
      from_mem_ff <= from_mem_in;
   end

   assign res = '{accepted:        acc_ff,
                  received_count:  rcv_ff,
                  delivered_count: dlv_ff,
                  dropped_count:   drp_ff,
                  occupancy:       dtlq_pkg::OCC_W'(fill_ff),
                  delay_total:     wsum_ff,
                  delay_count:     wcnt_ff,
                  last_departure:  recent_ff};

endmodule

[src/drop_tail_link_queue_model_top.sv]
// Top level of the drop-tail link queue model: ports, registers, packet store, result register.
//
// One item is in flight at a time. An arrival that releases no packet passes through the
// check, insert and done states, plus head service start (one multiply step, one add step)
// when it enters an empty queue. Each packet that departs adds a check, a pop, a read of the
// packet store with the multiply, and the add; the packet that empties the queue adds only a
// check and a pop. A flush on an empty queue goes from the check straight to done. The
// finished result sits in an output register, so the next item is taken while it waits.
module drop_tail_link_queue_model_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [63:0]                         req_tdata,  // arrival_time, size_bytes
   input  logic                                req_tuser,  // opcode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // received_count, delivered_count, dropped_count, occupancy, delay_total,
   // delay_count, last_departure
   output logic [dtlq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser,  // accepted
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dtlq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dtlq_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic [dtlq_pkg::BP_W-1:0]    bit_period_ff, bit_period_in;
   logic [dtlq_pkg::LIM_W-1:0]   queue_limit_ff, queue_limit_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   dtlq_pkg::result_type         rsp_ff, rsp_in;

   dtlq_pkg::item_type           item;
   dtlq_pkg::mem_req_type        mem_req;
   logic [dtlq_pkg::ENTRY_W-1:0] mem_rdata;
   logic                         res_valid;
   logic                         res_ready;
   dtlq_pkg::result_type         res;

   assign csr_ready = 1'b1;

   always_comb begin
      bit_period_in  = bit_period_ff;
      queue_limit_in = queue_limit_ff;
      if (csr_valid) begin
         unique case (csr_index)
            dtlq_pkg::CSR_BIT_PERIOD:  bit_period_in  = csr_data;
            dtlq_pkg::CSR_QUEUE_LIMIT: queue_limit_in = csr_data[dtlq_pkg::LIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign item = '{opcode:       req_tuser,
                   arrival_time: req_tdata[dtlq_pkg::TIME_W-1:0],
                   size_bytes:   req_tdata[dtlq_pkg::ENTRY_W-1:dtlq_pkg::TIME_W]};

   dtlq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (req_tvalid),
      .item_ready  (req_tready),
      .item        (item),
      .bit_period  (bit_period_ff),
      .queue_limit (queue_limit_ff),
      .mem_req     (mem_req),
      .mem_rdata   (mem_rdata),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   dtlq_ram #(
      .WIDTH (dtlq_pkg::ENTRY_W),
      .DEPTH (dtlq_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rdata)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff  <= dtlq_pkg::BIT_PERIOD_RESET;
         queue_limit_ff <= dtlq_pkg::QUEUE_LIMIT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         bit_period_ff  <= bit_period_in;
         queue_limit_ff <= queue_limit_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.accepted;
   assign rsp_tdata  = {rsp_ff.last_departure, rsp_ff.delay_count, rsp_ff.delay_total,
                        rsp_ff.occupancy, rsp_ff.dropped_count, rsp_ff.delivered_count,
                        rsp_ff.received_count};

   a_accept_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item taken while another is in flight");

   a_queued_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.accepted |-> rsp_ff.occupancy != '0)
      else $error("queued arrival reported with empty buffer");

   a_no_write_read_clash: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.wr_en && mem_req.rd_en))
      else $error("packet store written and read in the same cycle");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_ready |=> rsp_valid_ff)
      else $error("finished result not captured");

endmodule

[verif/link_queue_checker.sv]
// Checker for the drop-tail link queue: predicts each item's statistics and compares results.
module link_queue_checker
   import dtlq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [63:0]           req_tdata,  // arrival_time, size_bytes
   input  logic                  req_tuser,  // opcode
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // received_count, delivered_count, dropped_count, occupancy, delay_total,
   // delay_count, last_departure
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,  // accepted
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending,
   output int                    checked,
   output int                    peak_fill,
   output int                    drops_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [TIME_W-1:0] TIME_TOP = '1;

   logic [ENTRY_W-1:0] slots [DEPTH];
   logic [ADDR_W-1:0]  head;
   logic [FILL_W-1:0]  fill;
   logic [TIME_W-1:0]  head_done;
   logic [TIME_W-1:0]  last_done;
   logic [CNT_W-1:0]   arrivals;
   logic [CNT_W-1:0]   departures;
   logic [CNT_W-1:0]   drops;
   logic [CNT_W-1:0]   samples;
   logic [SUM_W-1:0]   wait_total;
   logic [BP_W-1:0]    bit_period;
   logic [LIM_W-1:0]   queue_limit;
   result_type         expected_stats [$];
   int                 mismatches = 0;
   int                 results_seen = 0;
   int                 fill_high = 0;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
   endfunction

   // start service of the head packet and account for its queueing delay
   task automatic begin_service(input logic [TIME_W-1:0] start);
      logic [TIME_W-1:0] arr;
      logic [SIZE_W-1:0] bytes;
      logic [SUM_W:0]    sum;
      logic [SUM_W-1:0]  delay;
      logic [63:0]       finish;
      arr   = slots[head][TIME_W-1:0];
      bytes = slots[head][ENTRY_W-1:TIME_W];
      delay = (start >= arr) ? SUM_W'(start - arr) : '0;
      sum = {1'b0, wait_total} + {1'b0, delay};
      wait_total = sum[SUM_W] ? {SUM_W{1'b1}} : sum[SUM_W-1:0];
      samples = sat_inc(samples);
      finish = 64'(start) + 64'(bytes) * 64'd8 * 64'(bit_period);
      head_done = (finish > 64'(TIME_TOP)) ? TIME_TOP : finish[TIME_W-1:0];
   endtask

   task automatic release_head();
      last_done = head_done;
      head = head + 1'b1;
      fill = fill - 1'b1;
      departures = sat_inc(departures);
      if (fill != 0) begin
         begin_service(last_done);
      end
   endtask

   task automatic advance_link(input logic op, input logic [TIME_W-1:0] arr,
                               input logic [SIZE_W-1:0] bytes, output result_type res);
      int                cap;
      logic [ADDR_W-1:0] slot;
      cap = (int'(queue_limit) > DEPTH) ? DEPTH : int'(queue_limit);
      res = '0;
      if (op == OP_ARRIVAL) begin
         arrivals = sat_inc(arrivals);
         while (fill != 0 && head_done < arr) begin
            release_head();
         end
         if (int'(fill) < cap) begin
            slot = head + fill[ADDR_W-1:0];
            slots[slot] = {bytes, arr};
            fill = fill + 1'b1;
            res.accepted = 1'b1;
            if (fill == 1) begin
               begin_service(arr);
            end
         end else begin
            drops = sat_inc(drops);
         end
      end else begin
         while (fill != 0) begin
            release_head();
         end
      end
      res.received_count  = arrivals;
      res.delivered_count = departures;
      res.dropped_count   = drops;
      res.occupancy       = OCC_W'(fill);
      res.delay_total     = wait_total;
      res.delay_count     = samples;
      res.last_departure  = last_done;
   endtask

   task automatic compare(input string field, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            slots[i] = '0;
         end
         head        = '0;
         fill        = '0;
         head_done   = '0;
         last_done   = '0;
         arrivals    = '0;
         departures  = '0;
         drops       = '0;
         samples     = '0;
         wait_total  = '0;
         bit_period  = BIT_PERIOD_RESET;
         queue_limit = QUEUE_LIMIT_RESET;
         expected_stats.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.accepted        = rsp_tuser;
            got.received_count  = rsp_tdata[31:0];
            got.delivered_count = rsp_tdata[63:32];
            got.dropped_count   = rsp_tdata[95:64];
            got.occupancy       = rsp_tdata[103:96];
            got.delay_total     = rsp_tdata[167:104];
            got.delay_count     = rsp_tdata[199:168];
            got.last_departure  = rsp_tdata[247:200];
            if (expected_stats.size() == 0) begin
               $error("result transaction with no item outstanding");
               mismatches++;
            end else begin
               want = expected_stats.pop_front();
               compare("accepted", 64'(want.accepted), 64'(got.accepted));
               compare("received_count", 64'(want.received_count),
                       64'(got.received_count));
               compare("delivered_count", 64'(want.delivered_count),
                       64'(got.delivered_count));
               compare("dropped_count", 64'(want.dropped_count), 64'(got.dropped_count));
               compare("occupancy", 64'(want.occupancy), 64'(got.occupancy));
               compare("delay_total", want.delay_total, got.delay_total);
               compare("delay_count", 64'(want.delay_count), 64'(got.delay_count));
               compare("last_departure", 64'(want.last_departure),
                       64'(got.last_departure));
               results_seen++;
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_BIT_PERIOD) begin
               bit_period = csr_data;
            end else if (csr_index == CSR_QUEUE_LIMIT) begin
               queue_limit = csr_data[LIM_W-1:0];
            end
         end
         if (req_tvalid && req_tready) begin
            advance_link(req_tuser, req_tdata[TIME_W-1:0], req_tdata[63:TIME_W], want);
            expected_stats.push_back(want);
            if (int'(fill) > fill_high) begin
               fill_high = int'(fill);
            end
         end
      end
      fail_count <= mismatches;
      pending    <= expected_stats.size();
      checked    <= results_seen;
      peak_fill  <= fill_high;
      drops_seen <= int'(drops);
   end

endmodule

[verif/tb_drop_tail_link_queue_model_top.sv]
// Testbench top: clock, reset, directed and random traffic, link settings and the verdict.
module tb_drop_tail_link_queue_model_top;
   timeunit 1ns;
   timeprecision 1ps;
   import dtlq_pkg::*;

   localparam logic [TIME_W-1:0]    TIME_TOP    = '1;
   localparam logic [CSR_IDX_W-1:0] CSR_NONE_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_NONE_HI = CSR_IDX_W'(3);

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [63:0]           req_tdata  = '0;
   logic                  req_tuser  = OP_ARRIVAL;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   int                    fail_count;
   int                    pending;
   int                    checked;
   int                    peak_fill;
   int                    drops_seen;
   int                    send_idle = 23;
   int                    recv_idle = 76;
   int                    arrivals_sent = 0;
   int                    flushes_sent = 0;
   logic [TIME_W-1:0]     trace_time = '0;

   drop_tail_link_queue_model_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   link_queue_checker stats_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked),
      .peak_fill  (peak_fill),
      .drops_seen (drops_seen)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
   end

   task automatic send_item(input logic op, input logic [TIME_W-1:0] t,
                            input logic [SIZE_W-1:0] sz);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {sz, t};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      if (op == OP_ARRIVAL) begin
         arrivals_sent++;
      end else begin
         flushes_sent++;
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value,
                            input bit lower);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      if (lower) begin
         csr_valid <= 1'b0;
      end
   endtask

   // hold off until every outstanding result has been taken
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic set_link(input logic [BP_W-1:0] bp, input logic [LIM_W-1:0] lim);
      write_csr(CSR_BIT_PERIOD, bp, 1'b0);
      write_csr(CSR_QUEUE_LIMIT, {(CSR_DATA_W - LIM_W)'($urandom), lim}, 1'b1);
   endtask

   task automatic run_phase(input logic [BP_W-1:0] bp, input logic [LIM_W-1:0] lim,
                            input int spacing_pct, input int s_idle, input int r_idle);
      logic [63:0]       svc;
      logic [63:0]       step;
      logic [63:0]       nxt;
      logic [SIZE_W-1:0] sz;
      int                roll;
      drain();
      set_link(bp, lim);
      send_idle = s_idle;
      recv_idle = r_idle;
      svc = 64'd4800 * 64'(bp);
      for (int n = 0; n < 135; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            send_item(OP_FLUSH, TIME_W'({$urandom, $urandom}), SIZE_W'($urandom));
            if ($urandom_range(0, 3) == 0) begin
               trace_time = TIME_W'({$urandom, $urandom}) >> 1;
            end
         end else if (roll < 9) begin
            send_item(OP_ARRIVAL, TIME_W'({$urandom, $urandom}), SIZE_W'($urandom));
         end else begin
            case ($urandom_range(0, 9))
               0: sz = '0;
               1: sz = '1;
               2: sz = SIZE_W'($urandom);
               default: sz = SIZE_W'($urandom_range(40, 1500));
            endcase
            step = svc * 64'($urandom_range(0, spacing_pct)) / 64'd100
                   + 64'($urandom_range(0, 3));
            nxt = 64'(trace_time) + step;
            trace_time = (nxt > 64'(TIME_TOP)) ? TIME_TOP : nxt[TIME_W-1:0];
            send_item(OP_ARRIVAL, trace_time, sz);
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(OP_ARRIVAL, '0, '0);
      send_item(OP_ARRIVAL, '0, '1);
      send_item(OP_ARRIVAL, TIME_W'(1), SIZE_W'(1));
      send_item(OP_ARRIVAL, TIME_W'(50), SIZE_W'(100));
      send_item(OP_ARRIVAL, TIME_W'(10), SIZE_W'(20));
      send_item(OP_FLUSH, '1, '1);
      send_item(OP_FLUSH, '0, '0);
      drain();
      write_csr(CSR_NONE_LO, CSR_DATA_W'($urandom), 1'b0);
      write_csr(CSR_NONE_HI, CSR_DATA_W'($urandom), 1'b0);
      set_link(BIT_PERIOD_RESET, '0);
      send_item(OP_ARRIVAL, TIME_W'(200), SIZE_W'(5));
      send_item(OP_ARRIVAL, TIME_TOP, '1);
      drain();
      set_link('1, LIM_W'(2));
      send_item(OP_ARRIVAL, TIME_TOP - 1'b1, '1);
      send_item(OP_ARRIVAL, TIME_TOP, '1);
      send_item(OP_ARRIVAL, TIME_TOP, '0);
      send_item(OP_FLUSH, '0, '0);
      drain();
      set_link(BP_W'(1), '1);
      send_item(OP_ARRIVAL, TIME_W'(100), SIZE_W'(3));
      send_item(OP_ARRIVAL, TIME_W'(100), SIZE_W'(3));
      send_item(OP_ARRIVAL, TIME_W'(90), '0);
      send_item(OP_ARRIVAL, TIME_W'(200), SIZE_W'(7));
      send_item(OP_FLUSH, '0, '0);

      run_phase(BP_W'(8), LIM_W'(100), 250, 23, 76);
      run_phase(BP_W'(1), LIM_W'(1), 200, 23, 76);
      run_phase('1, '1, 10, 76, 23);
      run_phase(BP_W'(200), LIM_W'(16), 150, 76, 23);
      run_phase('0, LIM_W'(128), 100, 0, 0);
      run_phase(BP_W'(77), LIM_W'(3), 300, 0, 0);
      drain();

      $display("Covered %0d arrivals and %0d flushes over ten link settings; %0d results checked.",
               arrivals_sent, flushes_sent, checked);
      $display("Peak occupancy %0d with %0d drops, under both stall mixes and a stall-free stretch.",
               peak_fill, drops_seen);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

[filelist.f]
src/dtlq_pkg.sv
src/dtlq_ram.sv
src/dtlq_ctrl.sv
src/drop_tail_link_queue_model_top.sv
verif/link_queue_checker.sv
verif/tb_drop_tail_link_queue_model_top.sv
